/* rtl/core/eald_pkg.sv */
// Shared types, widths and constants for the edge angle and length descriptor.
// Used by every module of the core and by its checker; depends on nothing.
package eald_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;   // exact difference of two coordinates
    localparam int SQ_W      = 2 * DIFF_W;    // square of a difference magnitude
    localparam int REM_W     = 68;            // sum of three squares
    localparam int ROOT_W    = 36;            // floor square root of a REM_W value
    localparam int XY_W      = 36;            // vectoring datapath, signed
    localparam int Z_W       = 34;            // angle accumulator, signed Q2.30
    localparam int ANG_W     = 18;            // angle result, Q2.16
    localparam int DIST_W    = 34;            // length result, Q18.16
    localparam int LANES     = 3;
    localparam int ROUND_SH  = 14;            // Q2.30 to Q2.16
    localparam int ATAN_ENTRIES = 32;

    localparam int ANGLE_ITERATIONS = 18;

    localparam logic [ANG_W-1:0] PI_Q16      = 18'd205887;
    localparam logic [ANG_W-1:0] HALF_PI_Q16 = 18'd102944;
    localparam logic [ANG_W-1:0] ZERO_Q16    = 18'd0;
    localparam logic [Z_W-1:0]   HALF_PI_Q30 = 34'd1686629713;
    localparam logic [Z_W-1:0]   ROUND_HALF  = 34'd8192;

    // arctan(2^-i) in Q2.30
    localparam logic [Z_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        34'd843314857, 34'd497837829, 34'd263043837, 34'd133525159,
        34'd67021687,  34'd33543516,  34'd16775851,  34'd8388437,
        34'd4194283,   34'd2097149,   34'd1048576,   34'd524288,
        34'd262144,    34'd131072,    34'd65536,     34'd32768,
        34'd16384,     34'd8192,      34'd4096,      34'd2048,
        34'd1024,      34'd512,       34'd256,       34'd128,
        34'd64,        34'd32,        34'd16,        34'd8,
        34'd4,         34'd2,         34'd1,         34'd0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } t_in;

    typedef struct packed {
        logic [ANG_W-1:0]  azimuth_from_x;
        logic [ANG_W-1:0]  azimuth_from_y;
        logic [ANG_W-1:0]  polar_from_z;
        logic [DIST_W-1:0] distance;
    } t_out;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
    } t_diff;

    typedef struct packed {
        logic [REM_W-1:0]  rem_p;
        logic [ROOT_W-1:0] root_p;
        logic [REM_W-1:0]  rem_d;
        logic [ROOT_W-1:0] root_d;
        t_diff             diff;
    } t_sqrt_st;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   special;
        logic [ANG_W-1:0]       spec_val;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lane;
        logic [DIST_W-1:0] length_val;
    } t_cordic_st;

    // Set up one atan2(y, x) lane, y >= 0: catch the axis cases, fold x < 0.
    function automatic t_lane lane_init(input logic signed [XY_W-1:0] x,
                                        input logic signed [XY_W-1:0] y);
        t_lane l;
        l.x        = x;
        l.y        = y;
        l.z        = '0;
        l.special  = 1'b0;
        l.spec_val = ZERO_Q16;
        if (y == '0) begin
            l.special = 1'b1;
            if (x[XY_W-1]) begin
                l.spec_val = PI_Q16;
            end else if (x != '0) begin
                l.spec_val = ZERO_Q16;
            end else begin
                l.spec_val = HALF_PI_Q16;
            end
        end else if (x == '0) begin
            l.special  = 1'b1;
            l.spec_val = HALF_PI_Q16;
        end else if (x[XY_W-1]) begin
            l.x = y;
            l.y = -x;
            l.z = HALF_PI_Q30;
        end
        return l;
    endfunction

    // Round the accumulator to Q2.16 and clamp to 0..pi; an axis-case lane gives its preset value.
    function automatic logic [ANG_W-1:0] lane_angle(input t_lane l);
        logic [Z_W-1:0]          sum;
        logic [Z_W-ROUND_SH-1:0] q;
        logic [ANG_W-1:0]        res;
        sum = l.z + ROUND_HALF;
        q   = sum[Z_W-1:ROUND_SH];
        if (l.special) begin
            res = l.spec_val;
        end else if (l.z[Z_W-1]) begin
            res = ZERO_Q16;
        end else if (q > (Z_W-ROUND_SH)'(PI_Q16)) begin
            res = PI_Q16;
        end else begin
            res = q[ANG_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/core/eald_sqrt_cell.sv */
// One digit cell of the two restoring square root chains (planar and full length).
// Depends on eald_pkg.
module eald_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  eald_pkg::t_sqrt_st   i_st,
    output eald_pkg::t_sqrt_st   o_st
);
    localparam int TW = 2 * eald_pkg::ROOT_W;

    logic [TW-1:0]        trial_p;
    logic [TW-1:0]        trial_d;
    eald_pkg::t_sqrt_st   n_st;
    eald_pkg::t_sqrt_st   r_st;

    // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
    always_comb begin
        trial_p = (TW'(i_st.root_p) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        trial_d = (TW'(i_st.root_d) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        n_st    = i_st;
        if (TW'(i_st.rem_p) >= trial_p) begin
            n_st.rem_p  = i_st.rem_p - trial_p[eald_pkg::REM_W-1:0];
            n_st.root_p = i_st.root_p | (eald_pkg::ROOT_W'(1) << BIT);
        end
        if (TW'(i_st.rem_d) >= trial_d) begin
            n_st.rem_d  = i_st.rem_d - trial_d[eald_pkg::REM_W-1:0];
            n_st.root_d = i_st.root_d | (eald_pkg::ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

/* rtl/core/eald_cordic_cell.sv */
// One vectoring CORDIC stage for the three angle lanes; carries the length along.
// Depends on eald_pkg.
module eald_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  eald_pkg::t_cordic_st   i_st,
    output eald_pkg::t_cordic_st   o_st
);
    eald_pkg::t_cordic_st n_st;
    eald_pkg::t_cordic_st r_st;

    always_comb begin
        n_st = i_st;
        for (int l = 0; l < eald_pkg::LANES; l++) begin
            // rotate toward the x axis; y == 0 takes the negative direction
            if (!i_st.lane[l].y[eald_pkg::XY_W-1] && (i_st.lane[l].y != '0)) begin
                n_st.lane[l].x = i_st.lane[l].x + (i_st.lane[l].y >>> STAGE);
                n_st.lane[l].y = i_st.lane[l].y - (i_st.lane[l].x >>> STAGE);
                n_st.lane[l].z = i_st.lane[l].z + eald_pkg::ATAN_TABLE[STAGE];
            end else begin
                n_st.lane[l].x = i_st.lane[l].x - (i_st.lane[l].y >>> STAGE);
                n_st.lane[l].y = i_st.lane[l].y + (i_st.lane[l].x >>> STAGE);
                n_st.lane[l].z = i_st.lane[l].z - eald_pkg::ATAN_TABLE[STAGE];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

/* rtl/core/edge_angle_length_descriptor_core.sv */
// Pipeline: the result passes through 42 + ANGLE_ITERATIONS register stages between the input transfer
//   and the edge at which it can transfer.
// Throughput: one point pair per cycle; the whole pipeline advances together and holds
//   only while the output register is full and not taken.
// Reset (synchronous, active low) clears all stage valid bits and drops input ready.
// Depends on eald_pkg, eald_sqrt_cell and eald_cordic_cell.
module edge_angle_length_descriptor_core #(
    parameter int ANGLE_ITERATIONS = eald_pkg::ANGLE_ITERATIONS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  eald_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output eald_pkg::t_out   o_out_data
);
    // front: diff, squares, planar sum, full sum; then one cell per root bit,
    // lane setup, one cell per CORDIC stage, output register
    localparam int FRONT_STG = 4;
    localparam int NSTG      = FRONT_STG + eald_pkg::ROOT_W + 1 + ANGLE_ITERATIONS + 1;
    localparam int DW        = eald_pkg::DIFF_W;
    localparam int XW        = eald_pkg::XY_W;

    logic                  adv;
    logic [NSTG-1:0]       r_valid;

    eald_pkg::t_diff       r_diff;
    eald_pkg::t_diff       r_diff1;
    eald_pkg::t_diff       r_diff2;
    logic [DW-1:0]         mag_x;
    logic [DW-1:0]         mag_y;
    logic [DW-1:0]         mag_z;
    logic [eald_pkg::SQ_W-1:0]  r_sqx;
    logic [eald_pkg::SQ_W-1:0]  r_sqy;
    logic [eald_pkg::SQ_W-1:0]  r_sqz;
    logic [eald_pkg::SQ_W-1:0]  r_sqz2;
    logic [eald_pkg::REM_W-1:0] r_sum_p;
    eald_pkg::t_sqrt_st    r_sqrt_in;
    eald_pkg::t_sqrt_st    w_sqrt [eald_pkg::ROOT_W+1];

    logic [DW-1:0]         mag_dx5;
    logic [DW-1:0]         mag_dy5;
    eald_pkg::t_cordic_st  r_cor_in;
    eald_pkg::t_cordic_st  w_cor [ANGLE_ITERATIONS+1];
    eald_pkg::t_out        r_out;

    // Advance everything unless the result at the output is stalled.
    assign adv        = !r_valid[NSTG-1] || i_out_ready;
    // Take no transfer while reset is held.
    assign o_in_ready = adv && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (adv) begin
            r_valid <= {r_valid[NSTG-2:0], i_in_valid};
        end
    end

    // Stage 0: exact differences.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_diff.dx <= DW'(i_in_data.second_x) - DW'(i_in_data.first_x);
            r_diff.dy <= DW'(i_in_data.second_y) - DW'(i_in_data.first_y);
            r_diff.dz <= DW'(i_in_data.second_z) - DW'(i_in_data.first_z);
        end
    end

    // Stage 1: squared magnitudes.
    always_comb begin
        mag_x = r_diff.dx[DW-1] ? DW'(-r_diff.dx) : DW'(r_diff.dx);
        mag_y = r_diff.dy[DW-1] ? DW'(-r_diff.dy) : DW'(r_diff.dy);
        mag_z = r_diff.dz[DW-1] ? DW'(-r_diff.dz) : DW'(r_diff.dz);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqx   <= mag_x * mag_x;
            r_sqy   <= mag_y * mag_y;
            r_sqz   <= mag_z * mag_z;
            r_diff1 <= r_diff;
        end
    end

    // Stage 2: planar sum. Stage 3: full sum, seed both root chains.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum_p <= eald_pkg::REM_W'(r_sqx) + eald_pkg::REM_W'(r_sqy);
            r_sqz2  <= r_sqz;
            r_diff2 <= r_diff1;

            r_sqrt_in.rem_p  <= r_sum_p;
            r_sqrt_in.rem_d  <= r_sum_p + eald_pkg::REM_W'(r_sqz2);
            r_sqrt_in.root_p <= '0;
            r_sqrt_in.root_d <= '0;
            r_sqrt_in.diff   <= r_diff2;
        end
    end

    // Root chains: one cell per result bit, most significant first.
    assign w_sqrt[0] = r_sqrt_in;

    for (genvar k = 0; k < eald_pkg::ROOT_W; k++) begin : g_sqrt
        eald_sqrt_cell #(
            .BIT (eald_pkg::ROOT_W - 1 - k)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_st  (w_sqrt[k]),
            .o_st  (w_sqrt[k+1])
        );
    end

    // Lane setup: x azimuth, y azimuth, polar angle from z.
    always_comb begin
        mag_dx5 = w_sqrt[eald_pkg::ROOT_W].diff.dx[DW-1] ?
                  DW'(-w_sqrt[eald_pkg::ROOT_W].diff.dx) : DW'(w_sqrt[eald_pkg::ROOT_W].diff.dx);
        mag_dy5 = w_sqrt[eald_pkg::ROOT_W].diff.dy[DW-1] ?
                  DW'(-w_sqrt[eald_pkg::ROOT_W].diff.dy) : DW'(w_sqrt[eald_pkg::ROOT_W].diff.dy);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cor_in.lane[0] <= eald_pkg::lane_init(
                {{(XW-DW){w_sqrt[eald_pkg::ROOT_W].diff.dx[DW-1]}},
                 w_sqrt[eald_pkg::ROOT_W].diff.dx},
                {{(XW-DW){1'b0}}, mag_dy5});
            r_cor_in.lane[1] <= eald_pkg::lane_init(
                {{(XW-DW){w_sqrt[eald_pkg::ROOT_W].diff.dy[DW-1]}},
                 w_sqrt[eald_pkg::ROOT_W].diff.dy},
                {{(XW-DW){1'b0}}, mag_dx5});
            r_cor_in.lane[2] <= eald_pkg::lane_init(
                {{(XW-DW){w_sqrt[eald_pkg::ROOT_W].diff.dz[DW-1]}},
                 w_sqrt[eald_pkg::ROOT_W].diff.dz},
                $signed(w_sqrt[eald_pkg::ROOT_W].root_p));
            r_cor_in.length_val <= w_sqrt[eald_pkg::ROOT_W].root_d[eald_pkg::DIST_W-1:0];
        end
    end

    // CORDIC chain: one cell per iteration.
    assign w_cor[0] = r_cor_in;

    for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cordic
        eald_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_st  (w_cor[k]),
            .o_st  (w_cor[k+1])
        );
    end

    // Output register: round, clamp and hold until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.azimuth_from_x <= eald_pkg::lane_angle(w_cor[ANGLE_ITERATIONS].lane[0]);
            r_out.azimuth_from_y <= eald_pkg::lane_angle(w_cor[ANGLE_ITERATIONS].lane[1]);
            r_out.polar_from_z   <= eald_pkg::lane_angle(w_cor[ANGLE_ITERATIONS].lane[2]);
            r_out.distance       <= w_cor[ANGLE_ITERATIONS].length_val;
        end
    end

    assign o_out_valid = r_valid[NSTG-1];
    assign o_out_data  = r_out;

endmodule

/* rtl/core/eald_checker.sv */
// Port-level checks for edge_angle_length_descriptor_core, bound to the top level.
// Depends on eald_pkg.
module eald_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input eald_pkg::t_out  o_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transfer dropped or changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (i_rst_n && (!o_out_valid || i_out_ready)))
        else $error("input ready does not follow output stall");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.azimuth_from_x <= eald_pkg::PI_Q16) &&
                        (o_out_data.azimuth_from_y <= eald_pkg::PI_Q16) &&
                        (o_out_data.polar_from_z <= eald_pkg::PI_Q16))
        else $error("angle above pi");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.distance == '0) |->
            (o_out_data.azimuth_from_x == eald_pkg::HALF_PI_Q16) &&
            (o_out_data.azimuth_from_y == eald_pkg::HALF_PI_Q16) &&
            (o_out_data.polar_from_z == eald_pkg::HALF_PI_Q16))
        else $error("zero vector angles not pi/2");

endmodule

bind edge_angle_length_descriptor_core eald_checker u_eald_checker (.*);
